// ===== src/cklb_pkg.sv =====
// ----------------------------------------------------------------------------
// Compound key lower bound search package
// Sizes, record layout, command codes and sequencer states for the search
// block; the record and compare result types are shared with its compare unit.
// ----------------------------------------------------------------------------
package cklb_pkg;

  localparam int NUM_TABLES    = 8;
  localparam int TABLE_ENTRIES = 256;

  localparam int TBL_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int POS_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W = TBL_W + POS_W;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_COUNT  = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  typedef struct packed {
    logic [7:0]         cls;
    logic signed [15:0] value;
  } rec_t;

  typedef struct packed {
    logic not_less;
    logic equal;
  } cmp_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_WAIT,
    ST_FINAL
  } state_t;

endpackage

// ===== src/compound_key_lower_bound_search.sv =====
// ----------------------------------------------------------------------------
// Compound key lower bound search
// Sorted record tables with a lower bound binary search over one table.
// ----------------------------------------------------------------------------
// Record writes and count sets take effect as they are accepted. A search
// runs over at most ceil(log2(count + 1)) probes, each a registered read of
// the record memory followed by a compare in the shared compare unit; it
// then reads the record at the bound and posts the result. The block takes
// no new transaction while a search runs, and a finished search holds until
// the previous result has been taken.
module compound_key_lower_bound_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         cmd,
  input  logic [2:0]         table_index,
  input  logic [7:0]         record_position,
  input  logic [8:0]         entry_count,
  input  logic signed [15:0] key_value,
  input  logic [7:0]         key_class,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               found,
  output logic [7:0]         bound_position
);
  import cklb_pkg::*;

  rec_t               mem [0:(1 << ADDR_W) - 1];
  logic [CNT_W-1:0]   counts [0:NUM_TABLES-1];

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   lo_next;
  logic [CNT_W-1:0]   hi_ex;
  logic [CNT_W-1:0]   hi_ex_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic               miss;
  logic               miss_next;
  logic [TBL_W-1:0]   tbl;
  rec_t               key;
  rec_t               rd_data;

  logic               accept;
  logic               tbl_ok;
  logic [TBL_W-1:0]   tbl_idx;
  logic [POS_W-1:0]   pos_idx;
  logic [CNT_W-1:0]   count_sat;
  logic [CNT_W:0]     mid_sum;
  logic [POS_W-1:0]   mid;
  logic               rd_en;
  logic [POS_W-1:0]   rd_idx;
  logic               load_out;
  cmp_res_t           cmp;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign tbl_ok    = (32'(table_index) < 32'(NUM_TABLES));
  assign tbl_idx   = TBL_W'(table_index);
  assign pos_idx   = POS_W'(record_position);
  assign count_sat = (32'(entry_count) > 32'(TABLE_ENTRIES)) ?
                     CNT_W'(TABLE_ENTRIES) : CNT_W'(entry_count);
  assign mid_sum   = {1'b0, lo} + {1'b0, hi_ex} - (CNT_W+1)'(1);
  assign mid       = POS_W'(mid_sum >> 1);

  cklb_cmp u_cmp (
    .rec (rd_data),
    .key (key),
    .res (cmp)
  );

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_WRITE && tbl_ok &&
        32'(record_position) < 32'(TABLE_ENTRIES)) begin
      mem[{tbl_idx, pos_idx}] <= '{cls: key_class, value: key_value};
    end
    if (rd_en) begin
      rd_data <= mem[{tbl, rd_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TABLES; i++) begin
        counts[i] <= '0;
      end
    end else if (accept && cmd == CMD_COUNT && tbl_ok) begin
      counts[tbl_idx] <= count_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_SEARCH) begin
      tbl <= tbl_idx;
      key <= '{cls: key_class, value: key_value};
    end
    lo    <= lo_next;
    hi_ex <= hi_ex_next;
    cnt   <= cnt_next;
    miss  <= miss_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_ex_next = hi_ex;
    cnt_next   = cnt;
    miss_next  = miss;
    rd_en      = 1'b0;
    rd_idx     = mid;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_SEARCH) begin
          lo_next    = '0;
          hi_ex_next = tbl_ok ? counts[tbl_idx] : '0;
          cnt_next   = tbl_ok ? counts[tbl_idx] : '0;
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo < hi_ex) begin
          rd_en      = 1'b1;
          rd_idx     = mid;
          state_next = ST_WAIT;
        end else if (lo < cnt) begin
          rd_en      = 1'b1;
          rd_idx     = POS_W'(lo);
          miss_next  = 1'b0;
          state_next = ST_FINAL;
        end else begin
          miss_next  = 1'b1;
          state_next = ST_FINAL;
        end
      end
      ST_WAIT: begin
        if (cmp.not_less) begin
          hi_ex_next = CNT_W'(mid);
        end else begin
          lo_next = CNT_W'(mid) + CNT_W'(1);
        end
        state_next = ST_PROBE;
      end
      ST_FINAL: begin
        if (!rsp_valid || !rsp_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found          <= !miss && cmp.equal;
      bound_position <= (!miss && cmp.equal) ? 8'(lo) : 8'd0;
    end
  end

  a_rsp_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_FINAL)
    else $error("result posted without a finished search");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE || state == ST_WAIT) |-> lo <= hi_ex)
    else $error("search bounds crossed");

  a_bound_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE || state == ST_WAIT) |-> hi_ex <= cnt)
    else $error("upper search bound beyond table count");

endmodule

// ===== src/cklb_cmp.sv =====
// ----------------------------------------------------------------------------
// Record compare unit
// Orders a stored record against the search key by class, then by signed
// value, and flags an exact match.
// ----------------------------------------------------------------------------
module cklb_cmp (
  input  cklb_pkg::rec_t     rec,
  input  cklb_pkg::rec_t     key,
  output cklb_pkg::cmp_res_t res
);
  import cklb_pkg::*;

  always_comb begin
    if (rec.cls != key.cls) begin
      res.not_less = (rec.cls > key.cls);
    end else begin
      res.not_less = (rec.value >= key.value);
    end
    res.equal = (rec.cls == key.cls) && (rec.value == key.value);
  end

endmodule

// ===== dv/tb_compound_key_lower_bound_search.sv =====
// ----------------------------------------------------------------------------
// Compound key lower bound search testbench
// Fills the sorted record tables with sorted runs of records, sets their
// counts and searches them with keys that hit, miss next to a record, land
// past the end or hit an empty table. A scoreboard predicts each search
// result and checks every result the block returns, in order.
// ----------------------------------------------------------------------------
module tb_compound_key_lower_bound_search;
  import cklb_pkg::*;

  typedef struct {
    logic [1:0]         cmd;
    logic [2:0]         tbl;
    logic [7:0]         pos;
    logic [8:0]         cnt;
    logic signed [15:0] val;
    logic [7:0]         cls;
  } search_req_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] pos;
  } match_t;

  class lower_bound_scoreboard;
    rec_t        entries[NUM_TABLES][TABLE_ENTRIES];
    int          live_count[NUM_TABLES];
    match_t      expected_matches[$];
    int          errors;

    function new();
      errors = 0;
      foreach (entries[t, i]) entries[t][i] = '0;
      foreach (live_count[t]) live_count[t] = 0;
    endfunction

    function bit sorts_not_below(rec_t r, logic [7:0] cls, logic signed [15:0] val);
      if (r.cls != cls) return r.cls > cls;
      return r.value >= val;
    endfunction

    function void note_request(search_req_t r);
      int     lo;
      int     hi;
      int     mid;
      match_t m;
      case (r.cmd)
        CMD_WRITE: begin
          entries[r.tbl][r.pos].cls = r.cls;
          entries[r.tbl][r.pos].value = r.val;
        end
        CMD_COUNT: begin
          live_count[r.tbl] = (r.cnt > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(r.cnt);
        end
        CMD_SEARCH: begin
          lo = 0;
          hi = live_count[r.tbl] - 1;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (sorts_not_below(entries[r.tbl][mid], r.cls, r.val)) hi = mid - 1;
            else lo = mid + 1;
          end
          m = '0;
          if (lo < live_count[r.tbl] && entries[r.tbl][lo].cls == r.cls &&
              entries[r.tbl][lo].value == r.val) begin
            m.hit = 1'b1;
            m.pos = lo[7:0];
          end
          expected_matches.push_back(m);
        end
        default: ;
      endcase
    endfunction

    function void check_match(logic hit, logic [7:0] pos);
      match_t m;
      if (expected_matches.size() == 0) begin
        $error("unexpected result: found %0d, bound_position %0d", hit, pos);
        errors++;
        return;
      end
      m = expected_matches.pop_front();
      if (hit !== m.hit) begin
        $error("found: expected %0d, actual %0d", m.hit, hit);
        errors++;
      end
      if (pos !== m.pos) begin
        $error("bound_position: expected %0d, actual %0d", m.pos, pos);
        errors++;
      end
    endfunction
  endclass

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         RANDOM_ITEMS = 900;
  localparam int         IDLE_LIMIT = 4000;
  localparam int         TAIL_CYCLES = 30;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         cmd = CMD_UNUSED;
  logic [2:0]         table_index = '0;
  logic [7:0]         record_position = '0;
  logic [8:0]         entry_count = '0;
  logic signed [15:0] key_value = '0;
  logic [7:0]         key_class = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic               found;
  logic [7:0]         bound_position;

  lower_bound_scoreboard sb = new();

  bit filled[NUM_TABLES][TABLE_ENTRIES];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  compound_key_lower_bound_search uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .cmd(cmd),
    .table_index(table_index),
    .record_position(record_position),
    .entry_count(entry_count),
    .key_value(key_value),
    .key_class(key_class),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .found(found),
    .bound_position(bound_position)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_match(found, bound_position);
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** compound_key_lower_bound_search: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic search_req_t random_req();
    search_req_t r;
    r.cmd = 2'($urandom_range(2));
    r.tbl = 3'($urandom_range(NUM_TABLES - 1));
    r.pos = 8'($urandom);
    r.cnt = 9'($urandom);
    r.val = 16'($urandom);
    r.cls = 8'($urandom);
    return r;
  endfunction

  function automatic int filled_prefix(int t);
    int n;
    n = 0;
    while (n < TABLE_ENTRIES && filled[t][n]) n++;
    return n;
  endfunction

  function automatic search_req_t make_write(int t, int p, logic [7:0] c,
                                             logic signed [15:0] v);
    search_req_t r;
    r = random_req();
    r.cmd = CMD_WRITE;
    r.tbl = 3'(t);
    r.pos = 8'(p);
    r.cls = c;
    r.val = v;
    return r;
  endfunction

  function automatic search_req_t make_count(int t, int n);
    search_req_t r;
    r = random_req();
    r.cmd = CMD_COUNT;
    r.tbl = 3'(t);
    r.cnt = 9'(n);
    return r;
  endfunction

  function automatic search_req_t make_search(int t, logic [7:0] c,
                                              logic signed [15:0] v);
    search_req_t r;
    r = random_req();
    r.cmd = CMD_SEARCH;
    r.tbl = 3'(t);
    r.cls = c;
    r.val = v;
    return r;
  endfunction

  // Keys mostly come from the records in the live part of the table, as they
  // are, one value away, or with the class kept and a fresh value.
  function automatic search_req_t pick_search(int t);
    search_req_t r;
    rec_t        e;
    int          c;
    int          mode;
    r = make_search(t, 8'($urandom), 16'($urandom));
    c = sb.live_count[t];
    mode = $urandom_range(4);
    if (c > 0 && mode < 4) begin
      e = sb.entries[t][$urandom_range(c - 1)];
      r.cls = e.cls;
      case (mode)
        0, 1: r.val = e.value;
        2: r.val = $urandom_range(1) ? e.value + 16'sd1 : e.value - 16'sd1;
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic int pick_count(int t);
    int p;
    p = filled_prefix(t);
    return (p == TABLE_ENTRIES) ? $urandom_range(TABLE_ENTRIES * 2 - 1) :
                                  $urandom_range(p);
  endfunction

  task automatic send(search_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= r.cmd;
    table_index <= r.tbl;
    record_position <= r.pos;
    entry_count <= r.cnt;
    key_value <= r.val;
    key_class <= r.cls;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    if (r.cmd == CMD_WRITE) filled[r.tbl][r.pos] = 1'b1;
    if (r.cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_matches.size() != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    search_req_t r;
    int          t;
    t = $urandom_range(NUM_TABLES - 1);
    case ($urandom_range(3))
      0: begin
        r = random_req();
        r.cmd = CMD_UNUSED;
      end
      1: r = pick_search(t);
      2: r = make_write(t, $urandom_range(TABLE_ENTRIES - 1), 8'($urandom), 16'($urandom));
      default: r = make_count(t, pick_count(t));
    endcase
    send(r);
  endtask

  task automatic run_directed();
    search_req_t r;
    send(make_search(5, 8'd0, 16'sd0));
    send(make_write(0, 0, 8'd0, -16'sd32768));
    send(make_write(0, 1, 8'd0, 16'sd32767));
    send(make_write(0, 2, 8'd255, -16'sd32768));
    send(make_write(0, 3, 8'd255, 16'sd32767));
    send(make_write(7, 255, 8'd255, 16'sd32767));
    send(make_count(0, 4));
    send(make_search(0, 8'd0, -16'sd32768));
    send(make_search(0, 8'd0, 16'sd32767));
    send(make_search(0, 8'd255, -16'sd32768));
    send(make_search(0, 8'd255, 16'sd32767));
    send(make_search(0, 8'd0, 16'sd0));
    send(make_search(0, 8'd128, 16'sd0));
    send(make_count(0, 3));
    send(make_search(0, 8'd255, 16'sd32767));
    r = make_search(0, 8'd255, 16'sd32767);
    r.cmd = CMD_UNUSED;
    r.tbl = 3'd7;
    r.pos = 8'd255;
    r.cnt = 9'h1ff;
    send(r);
    send(make_count(0, 0));
    send(make_search(0, 8'd0, -16'sd32768));
    send(make_count(0, 4));
    send(make_search(0, 8'd255, 16'sd32767));
  endtask

  // One run: a table gets a sorted set of records, its count, and searches,
  // with unrelated transactions mixed in.
  task automatic run_episode(int ep);
    bit [23:0]          keys[$];
    int                 t;
    int                 n;
    int                 base;
    bit                 narrow;
    logic [7:0]         c;
    logic signed [15:0] v;
    t = $urandom_range(NUM_TABLES - 1);
    if (ep == 0) n = TABLE_ENTRIES;
    else if ($urandom_range(9) == 0) n = $urandom_range(80);
    else n = $urandom_range(1, 20);
    narrow = $urandom_range(1);
    base = $urandom_range(252);
    for (int i = 0; i < n; i++) begin
      c = narrow ? 8'(base + $urandom_range(3)) : 8'($urandom);
      v = narrow ? 16'($urandom_range(8) - 4) : 16'($urandom);
      if ($urandom_range(7) == 0) v = $urandom_range(1) ? -16'sd32768 : 16'sd32767;
      keys.push_back({c, v ^ 16'h8000});
    end
    keys.sort();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(11) == 0) send_noise();
      send(make_write(t, i, keys[i][23:16], keys[i][15:0] ^ 16'h8000));
    end
    if ($urandom_range(7) == 0) send(make_count(t, pick_count(t)));
    else if (n == TABLE_ENTRIES) send(make_count(t, $urandom_range(n, n * 2 - 1)));
    else send(make_count(t, n));
    for (int k = $urandom_range(3, 10); k > 0; k--) begin
      if ($urandom_range(9) == 0) send_noise();
      send(pick_search(t));
    end
  endtask

  initial begin
    int ep;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    drain();
    ep = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (ep % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      run_episode(ep);
      if (ep % 7 == 6) drain();
      ep++;
    end
    req_valid <= 1'b0;
    while (sb.expected_matches.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_matches.size() != 0) begin
      $error("%0d results never arrived", sb.expected_matches.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("** compound_key_lower_bound_search: PASSED **");
    end else begin
      $display("** compound_key_lower_bound_search: FAILED **");
    end
    $finish;
  end

endmodule
